@@ rtl/core/lgs_pkg.sv @@
// Package for the Game of Life grid engine: payload types, operation codes,
// FSM states and default sizes. Used by the top level and by the testbench.
`default_nettype none

package lgs_pkg;

  // Default grid size; the top level takes these as parameter defaults.
  localparam int COLS_DEF = 64;
  localparam int ROWS_DEF = 64;

  // Fixed widths of the channel fields.
  localparam int OP_W    = 2;
  localparam int INDEX_W = 6;
  localparam int ROW_W   = 64;

  // Operation codes on the command channel. Code 3 is unused and ignored.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  // Result kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] row_index;
    logic [ROW_W-1:0]   row_bits;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row_data;
  } rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/lgs_stream_if.sv @@
// Valid/ready channel interface for the Game of Life grid engine.
// The payload type is a parameter; lgs_pkg supplies the command and result types.
`default_nettype none

interface lgs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/life_grid_generation_step.sv @@
// Game of Life grid engine. The grid of ROWS by COLS cells lives in one RAM
// row per word and is cleared by a pass over all rows after reset, during
// which no command is taken. A row write is done in the idle state; a row
// read goes through the RAM read register and the output register and
// delivers a result of kind 0. A generation step streams every row through
// the RAM read port into a window of three row registers and writes each new
// row back once the row below it has been read; the result of kind 1 follows
// when every row is written back. One command is worked on at a time; a
// result waits in an output register while further commands are still taken.
`default_nettype none

module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  lgs_stream_if.sink   cmd,
  lgs_stream_if.source rsp
);

  localparam int AW = $clog2(ROWS);
  localparam int CW = $clog2(ROWS + 2);

  state_t state, state_next;

  logic [CW-1:0]   cnt;
  logic [COLS-1:0] up_row;
  logic [COLS-1:0] mid_row;
  logic [COLS-1:0] down_in;
  logic [COLS-1:0] new_row;
  logic            rd_zero;

  logic            rsp_vld;
  rsp_t            rsp_data;
  logic            rsp_load;
  logic            rsp_kind;
  logic            slot_free;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [COLS-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [COLS-1:0] ram_rdata;

  logic            row_ok;
  logic [AW-1:0]   row_addr;
  logic            take;

  lgs_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  lgs_row_rule #(
    .COLS (COLS)
  ) u_rule (
    .up   (up_row),
    .mid  (mid_row),
    .down (down_in),
    .next (new_row)
  );

  // Command decode helpers.
  assign row_ok    = 32'(cmd.payload.row_index) < 32'(ROWS);
  assign row_addr  = AW'(cmd.payload.row_index);
  assign take      = cmd.valid && cmd.ready;
  assign slot_free = !rsp_vld || rsp.ready;

  // The row below the last one is dead; otherwise it is the word just read.
  assign down_in = (cnt <= CW'(ROWS)) ? ram_rdata : '0;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (cnt == CW'(ROWS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.valid) begin
          unique case (cmd.payload.op)
            OP_READ: state_next = ST_READ;
            OP_STEP: state_next = ST_STEP;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (slot_free) state_next = ST_IDLE;
      end
      ST_STEP: begin
        if (cnt == CW'(ROWS + 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller: RAM ports, command ready and result load.
  // During a step, row cnt is read while row cnt-2 is written, so the two
  // ports never meet on one address and the old rows sit in the window.
  always_comb begin
    cmd.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    rsp_load  = 1'b0;
    rsp_kind  = KIND_READ;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt);
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          unique case (cmd.payload.op)
            OP_WRITE: begin
              ram_we    = row_ok;
              ram_waddr = row_addr;
              ram_wdata = cmd.payload.row_bits[COLS-1:0];
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = row_addr;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        rsp_load = slot_free;
      end
      ST_STEP: begin
        if (cnt < CW'(ROWS)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cnt);
        end
        if (cnt >= CW'(2)) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cnt - CW'(2));
          ram_wdata = new_row;
        end
      end
      ST_FINISH: begin
        rsp_load = slot_free;
        rsp_kind = KIND_STEP;
      end
      default: ;
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_STEP) begin
        cnt <= cnt + CW'(1);
      end else if (take) begin
        cnt <= '0;
      end
    end
  end

  // Row window and read flag; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      up_row  <= '0;
      mid_row <= '0;
      rd_zero <= !row_ok;
    end else if (state == ST_STEP && cnt >= CW'(1)) begin
      up_row  <= mid_row;
      mid_row <= down_in;
    end
  end

  // Output register: a new result is loaded only once the last one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data.kind     <= rsp_kind;
      rsp_data.row_data <= (rsp_kind == KIND_STEP || rd_zero) ? '0 : ROW_W'(ram_rdata);
    end
  end

  assign rsp.valid   = rsp_vld;
  assign rsp.payload = rsp_data;

  // The two RAM ports never address the same row in one cycle.
  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same row");

  // The finish state is reached only from the end of the step stream.
  a_finish_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_FINISH) |-> ($past(state) == ST_STEP)
                                  && ($past(cnt) == CW'(ROWS + 1)))
    else $error("step finished before all rows were written");

  // A step result never carries row data.
  a_step_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_vld && rsp_data.kind == KIND_STEP) |-> (rsp_data.row_data == '0))
    else $error("step result with row data");

  // The stream counter stays inside the step window.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (cnt <= CW'(ROWS + 1)))
    else $error("step counter out of range");

endmodule

`default_nettype wire

@@ rtl/core/lgs_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module lgs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lgs_row_rule.sv @@
// Life rule for one whole row: next cells from the old rows above, at and below.
// Columns outside the row count as dead. Depends on nothing but its parameter.
`default_nettype none

module lgs_row_rule #(
  parameter int COLS = 64
) (
  input  wire logic [COLS-1:0] up,
  input  wire logic [COLS-1:0] mid,
  input  wire logic [COLS-1:0] down,
  output logic      [COLS-1:0] next
);

  // Each column counts its eight neighbours and applies the birth and
  // survival rule on its own.
  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic       up_l, mid_l, down_l;
    logic       up_r, mid_r, down_r;
    logic [3:0] count;

    if (c > 0) begin : g_left
      assign up_l   = up[c-1];
      assign mid_l  = mid[c-1];
      assign down_l = down[c-1];
    end else begin : g_left_edge
      assign up_l   = 1'b0;
      assign mid_l  = 1'b0;
      assign down_l = 1'b0;
    end

    if (c < COLS - 1) begin : g_right
      assign up_r   = up[c+1];
      assign mid_r  = mid[c+1];
      assign down_r = down[c+1];
    end else begin : g_right_edge
      assign up_r   = 1'b0;
      assign mid_r  = 1'b0;
      assign down_r = 1'b0;
    end

    assign count = 4'(up_l) + 4'(up[c]) + 4'(up_r) + 4'(mid_l) + 4'(mid_r)
                 + 4'(down_l) + 4'(down[c]) + 4'(down_r);

    assign next[c] = (count == 4'd3) || ((count == 4'd2) && mid[c]);
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for life_grid_generation_step: random and directed row
// writes, row reads and generation steps, checked against a shadow grid.
// Depends on lgs_pkg, lgs_stream_if and the block's top level.
`timescale 1ns / 100ps

module testbench;
  import lgs_pkg::*;

  localparam int COLS = COLS_DEF;
  localparam int ROWS = ROWS_DEF;

  // Code 3 on the operation field is unused; the block must ignore it.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Neighbour counts of the life rule.
  localparam int unsigned BIRTH_COUNT   = 3;
  localparam int unsigned SURVIVE_COUNT = 2;

  localparam logic [ROW_W-1:0] COL_MASK =
      (COLS >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << COLS) - ROW_W'(1));

  localparam int STIMULUS_ITEMS = 1700;
  localparam int LIMIT_CYCLES   = 1_000_000;

  logic clk;
  logic rst;

  lgs_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  lgs_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  life_grid_generation_step #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // Commands waiting to be driven, and results the shadow grid says must come.
  cmd_t queued_cmds[$];
  rsp_t awaited_results[$];
  logic [ROW_W-1:0] shadow_grid[ROWS] = '{default: '0};

  int mismatches = 0;
  int stimulus_count = 0;
  int writes_seen = 0;
  int spares_seen = 0;
  int reads_checked = 0;
  int steps_checked = 0;

  bit drive_calm = 1'b0;
  bit sink_calm = 1'b0;
  int send_gap;
  int sink_gap;

  // Clock and reset.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int pause_for(input bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Next state of one row from the old rows above, at and below it.
  function automatic logic [ROW_W-1:0] next_generation_row(input logic [ROW_W-1:0] up,
                                                           input logic [ROW_W-1:0] mid,
                                                           input logic [ROW_W-1:0] down);
    logic [ROW_W-1:0] born;
    int unsigned n;
    born = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 0;
      for (int k = -1; k <= 1; k++) begin
        if (c + k >= 0 && c + k < COLS) begin
          n += up[c+k] + down[c+k];
          if (k != 0) n += mid[c+k];
        end
      end
      if (n == BIRTH_COUNT || (n == SURVIVE_COUNT && mid[c])) born[c] = 1'b1;
    end
    return born & COL_MASK;
  endfunction

  // Apply one transferred command to the shadow grid and note any result it owes.
  task automatic apply_command(input cmd_t c);
    logic [ROW_W-1:0] old_grid[ROWS];
    rsp_t r;
    r = '0;
    case (c.op)
      OP_WRITE: begin
        if (c.row_index < ROWS) shadow_grid[c.row_index] = c.row_bits & COL_MASK;
        writes_seen++;
      end
      OP_READ: begin
        r.kind = KIND_READ;
        r.row_data = (c.row_index < ROWS) ? shadow_grid[c.row_index] : '0;
        awaited_results.push_back(r);
      end
      OP_STEP: begin
        old_grid = shadow_grid;
        for (int i = 0; i < ROWS; i++) begin
          shadow_grid[i] = next_generation_row((i > 0) ? old_grid[i-1] : '0, old_grid[i],
                                               (i < ROWS - 1) ? old_grid[i+1] : '0);
        end
        r.kind = KIND_STEP;
        awaited_results.push_back(r);
      end
      default: begin
        spares_seen++;
      end
    endcase
  endtask

  // Stimulus helpers.
  task automatic push_cmd(input logic [OP_W-1:0] op, input int idx, input logic [ROW_W-1:0] bits);
    cmd_t c;
    c.op = op_t'(op);
    c.row_index = INDEX_W'(idx);
    c.row_bits = bits;
    queued_cmds.push_back(c);
    if (op != OP_SPARE) stimulus_count++;
  endtask

  task automatic push_write(input int idx, input logic [ROW_W-1:0] bits);
    push_cmd(OP_WRITE, idx, bits);
  endtask

  task automatic push_read(input int idx);
    push_cmd(OP_READ, idx, {$urandom, $urandom});
  endtask

  task automatic push_step();
    push_cmd(OP_STEP, $urandom_range(0, 63), {$urandom, $urandom});
  endtask

  // A random row whose density depends on the chosen level.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return a & b & c;
      2, 3: return a & b;
      4, 5: return a;
      6: return a | b;
      default: return '1;
    endcase
  endfunction

  // Command driver: holds each command until it is transferred, then may pause.
  always @(posedge clk) begin : drive_cmds
    int gap;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.payload <= '0;
      send_gap <= 0;
    end else if (!(cmd_ch.valid && !cmd_ch.ready)) begin
      if (cmd_ch.valid) begin
        if ($urandom_range(0, 39) == 0) drive_calm = !drive_calm;
        gap = pause_for(drive_calm);
      end else begin
        gap = send_gap;
      end
      if (gap == 0 && queued_cmds.size() > 0) begin
        cmd_ch.payload <= queued_cmds.pop_front();
        cmd_ch.valid <= 1'b1;
      end else begin
        cmd_ch.valid <= 1'b0;
        send_gap <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // Command monitor: every transfer updates the shadow grid.
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) apply_command(cmd_ch.payload);
  end

  // Result sink: random stalls, and each transfer checked against the oldest expectation.
  always @(posedge clk) begin : sink_results
    int gap;
    rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else if (rsp_ch.ready && rsp_ch.valid) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0b data %h",
                                  rsp_ch.payload.kind, rsp_ch.payload.row_data));
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.payload.kind !== want.kind)
          report_mismatch($sformatf("kind %0b, expected %0b", rsp_ch.payload.kind, want.kind));
        if (rsp_ch.payload.row_data !== want.row_data)
          report_mismatch($sformatf("row_data %h, expected %h (kind %0b)",
                                    rsp_ch.payload.row_data, want.row_data, want.kind));
        if (want.kind == KIND_STEP) steps_checked++;
        else reads_checked++;
      end
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      gap = pause_for(sink_calm);
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        sink_gap <= gap - 1;
      end
    end else if (!rsp_ch.ready) begin
      if (sink_gap == 0) rsp_ch.ready <= 1'b1;
      else sink_gap <= sink_gap - 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int base;
    int span;

    // Directed: cleared grid, ignored code, full rows at the grid edges,
    // edge columns, and a blinker stepped twice.
    push_read(0);
    push_read(63);
    push_cmd(OP_SPARE, 5, '1);
    push_read(5);
    push_write(0, '1);
    push_write(63, '1);
    push_write(31, 64'h8000_0000_0000_0001);
    push_write(40, 64'h7 << 30);
    push_read(0);
    push_read(63);
    push_step();
    push_read(0);
    push_read(1);
    push_read(31);
    push_read(39);
    push_read(40);
    push_read(41);
    push_read(62);
    push_read(63);
    push_step();
    push_read(1);
    push_read(40);

    // Random part: mostly populate, evolve and read back; some noise.
    while (stimulus_count < STIMULUS_ITEMS) begin
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(5, 15))
            push_cmd(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63), {$urandom, $urandom});
        end
        8: begin
          repeat ($urandom_range(2, 10)) push_read($urandom_range(0, 63));
        end
        9: begin
          repeat ($urandom_range(1, 4)) push_step();
          for (int i = 0; i < ROWS; i++) push_read(i);
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            for (int i = 0; i < ROWS; i++) push_write(i, random_row());
          end else begin
            base = $urandom_range(0, 63);
            span = $urandom_range(1, 12);
            for (int i = 0; i < span; i++) push_write((base + i) % ROWS, random_row());
          end
          repeat ($urandom_range(1, 3)) push_step();
          if ($urandom_range(0, 5) == 0) begin
            for (int i = 0; i < ROWS; i++) push_read(i);
          end else begin
            base = $urandom_range(0, 63);
            span = $urandom_range(2, 10);
            for (int i = 0; i < span; i++) push_read((base + i) % ROWS);
          end
        end
      endcase
    end

    @(negedge rst);
    while (queued_cmds.size() > 0 || cmd_ch.valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (ROWS + 8) @(posedge clk);
    if (awaited_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    $display("Covered %0d row writes, %0d ignored codes, %0d row reads and %0d generations.",
             writes_seen, spares_seen, reads_checked, steps_checked);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("** life_grid_generation_step: PASSED **");
    end else begin
      $display("** life_grid_generation_step: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Run timed out with %0d results outstanding.", awaited_results.size());
    $display("** life_grid_generation_step: FAILED **");
    $finish;
  end

endmodule
